@@ hdl/pmmdg_pkg.sv @@
// Package for the pair max/min/divides/GCD unit: widths, FSM states, control structs.
`timescale 1ns / 1ps
package pmmdg_pkg;

    // Fixed width of every numeric field on the ports
    localparam int unsigned FIELD_W   = 32;
    // Default operand width inside the unit
    localparam int unsigned WIDTH_DEF = 32;
    // Packed stream widths, padded to whole bytes
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 104;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;   // capture a new operand pair
        logic step;   // one binary GCD iteration
        logic store;  // move the finished result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic done;   // working values have converged (or an operand is zero)
    } t_dp_status;

endpackage

@@ hdl/pair_max_min_divides_gcd.sv @@
// Top level of the pair max/min/divides/GCD unit.
//
//  channel | dir | tdata fields (low bit up)                                   | beat taken
//  s_axis  | in  | first_value[31:0], second_value[63:32]                      | tvalid & tready
//  m_axis  | out | larger[31:0], smaller[63:32], divides[64], gcd[96:65],      | tvalid & tready
//          |     | zero_operand[97], zero pad[103:98]                          |
//
// Sequence: a beat is loaded in the idle state, Stein's binary GCD runs one shift or
// subtract-and-shift per cycle, and a store moves the result into the output register.
// Each step drops at least one operand bit; a zero operand goes straight to the store.
// Reset (i_rst_n, synchronous, active low) clears the state machine and the
// output valid and holds s_axis_tready low; payload registers are not reset.
// A stalled output holds its beat in the result register; the next pair is
// accepted and computed meanwhile and waits to be stored until that beat leaves.
`timescale 1ns / 1ps
module pair_max_min_divides_gcd
    import pmmdg_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // first_value, second_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // larger, smaller, divides, gcd, zero, pad
);

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic [FIELD_W-1:0] w_larger, w_smaller, w_gcd;
    logic               w_divides, w_zero;

    pmmdg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pmmdg_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_cmd               (w_cmd),
        .i_first_value       (s_axis_tdata[FIELD_W-1:0]),
        .i_second_value      (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .o_status            (w_status),
        .o_larger_value      (w_larger),
        .o_smaller_value     (w_smaller),
        .o_one_divides_other (w_divides),
        .o_common_divisor    (w_gcd),
        .o_zero_operand      (w_zero)
    );

    // Pack result fields, first field lowest, padded to whole bytes
    assign m_axis_tdata = {6'b0, w_zero, w_gcd, w_divides, w_smaller, w_larger};

endmodule

@@ hdl/pmmdg_dp.sv @@
// Datapath: operand ordering, binary GCD working registers and the result register.
`timescale 1ns / 1ps
module pmmdg_dp
    import pmmdg_pkg::*;
#(
    parameter int unsigned WIDTH = WIDTH_DEF
) (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic [FIELD_W-1:0] i_first_value,
    input  logic [FIELD_W-1:0] i_second_value,
    output t_dp_status         o_status,
    output logic [FIELD_W-1:0] o_larger_value,
    output logic [FIELD_W-1:0] o_smaller_value,
    output logic               o_one_divides_other,
    output logic [FIELD_W-1:0] o_common_divisor,
    output logic               o_zero_operand
);

    // Operands wider than the port carry nothing above the port width
    localparam int unsigned DW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
    localparam int unsigned KW = $clog2(DW);

    logic [DW-1:0] w_a_in, w_b_in, w_big, w_small, w_gcd;
    logic [DW-1:0] r_big, r_small, r_a, r_b, n_a, n_b;
    logic [KW-1:0] r_k, n_k;
    logic          r_zero;
    logic          w_a_ge_b;

    assign w_a_in  = i_first_value[DW-1:0];
    assign w_b_in  = i_second_value[DW-1:0];
    assign w_big   = (w_a_in > w_b_in) ? w_a_in : w_b_in;
    assign w_small = (w_a_in > w_b_in) ? w_b_in : w_a_in;

    assign w_a_ge_b = (r_a >= r_b);
    assign w_gcd    = r_a << r_k;

    assign o_status.done = r_zero || (r_a == r_b);

    // Stein's algorithm, one move per cycle
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        priority if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + KW'(1);
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (w_a_ge_b) begin
            n_a = (r_a - r_b) >> 1;
        end else begin
            n_b = (r_b - r_a) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_big   <= w_big;
            r_small <= w_small;
            r_a     <= w_big;
            r_b     <= w_small;
            r_k     <= '0;
            r_zero  <= (w_small == '0);
        end else if (i_cmd.step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end
    end

    // Result register; the smaller value divides the larger exactly when it is the GCD
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            o_larger_value      <= FIELD_W'(r_big);
            o_smaller_value     <= FIELD_W'(r_small);
            o_zero_operand      <= r_zero;
            o_one_divides_other <= !r_zero && (w_gcd == r_small);
            o_common_divisor    <= r_zero ? '0 : FIELD_W'(w_gcd);
        end
    end

endmodule

@@ hdl/pmmdg_ctrl.sv @@
// Controller: input/output handshakes and the run state machine.
`timescale 1ns / 1ps
module pmmdg_ctrl
    import pmmdg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_status.done) begin
                    o_cmd.step = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.store = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = o_cmd.store || (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

endmodule
